// ----- sv/lkvc_pkg.sv -----
`timescale 1ns / 1ps
// lkvc_pkg: shared constants for the lru key/value cache
// field widths, operation codes, capacity reset value, miss and put read values; no dependencies

package lkvc_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int FUNC_W = 1;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int CAP_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_GET = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_PUT = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;
  localparam logic [VAL_W-1:0] PUT_VALUE  = '0;

endpackage

// ----- sv/lkvc_cell.sv -----
`timescale 1ns / 1ps
// lkvc_cell: one cache slot (key, value, valid, recency rank) plus one scan stage
// depends on lkvc_pkg

module lkvc_cell #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF,
  parameter int IDX     = 0,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int RW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int SCAN_W  = 3 + 3 * IW + 2 * RW + lkvc_pkg::VAL_W,
  parameter int CMD_W   = 4 + IW + RW + lkvc_pkg::KEY_W + lkvc_pkg::VAL_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lkvc_pkg::KEY_W-1:0]  key_i,
  input  logic                        go_i,
  input  logic [SCAN_W-1:0]           scan_i,
  input  logic [CMD_W-1:0]            cmd_i,
  output logic                        go_o,
  output logic [SCAN_W-1:0]           scan_o,
  output logic                        valid_o
);
  import lkvc_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [IW-1:0]     hit_idx;
    logic [RW-1:0]     hit_rank;
    logic [VAL_W-1:0]  hit_value;
    logic              free;
    logic [IW-1:0]     free_idx;
    logic              any;
    logic [RW-1:0]     best;
    logic [IW-1:0]     victim;
  } scan_t;

  typedef struct packed {
    logic              upd;
    logic              age_all;
    logic              wr_key;
    logic              wr_val;
    logic [IW-1:0]     idx;
    logic [RW-1:0]     lim;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  scan_t            acc_in, acc_d, acc_q;
  cmd_t             cmd;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic             valid_q;
  logic [RW-1:0]    rank_q;
  logic             me;

  assign acc_in = scan_t'(scan_i);
  assign cmd    = cmd_t'(cmd_i);
  assign me     = (cmd.idx == IW'(IDX));

  always_comb begin
    acc_d = acc_in;
    if (!acc_in.hit && valid_q && (key_q == key_i)) begin
      acc_d.hit       = 1'b1;
      acc_d.hit_idx   = IW'(IDX);
      acc_d.hit_rank  = rank_q;
      acc_d.hit_value = val_q;
    end
    if (!acc_in.free && !valid_q) begin
      acc_d.free     = 1'b1;
      acc_d.free_idx = IW'(IDX);
    end
    if (valid_q && (!acc_in.any || (rank_q > acc_in.best))) begin
      acc_d.any    = 1'b1;
      acc_d.best   = rank_q;
      acc_d.victim = IW'(IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_o    <= 1'b0;
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      go_o <= go_i;
      if (cmd.upd) begin
        if (me) begin
          rank_q <= '0;
          if (cmd.wr_key) begin
            valid_q <= 1'b1;
          end
        end else if (valid_q && (cmd.age_all || (rank_q < cmd.lim))) begin
          rank_q <= rank_q + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      acc_q <= acc_d;
    end
    if (cmd.upd && me) begin
      if (cmd.wr_key) begin
        key_q <= cmd.key;
      end
      if (cmd.wr_val) begin
        val_q <= cmd.value;
      end
    end
  end

  assign scan_o  = SCAN_W'(acc_q);
  assign valid_o = valid_q;

endmodule

// ----- sv/lru_key_value_cache_top.sv -----
`timescale 1ns / 1ps
// lru_key_value_cache_top: fully associative key/value cache with lru replacement
// depends on lkvc_pkg and lkvc_cell
//
// usage
//   input channel (in_valid_i/in_ready_o) carries one word: func_i (0 get, 1 put),
//   key_i, value_i. output channel (out_valid_o/out_ready_i) returns one word per
//   input: found_o and read_value_o (value on get hit, all ones on get miss,
//   zero on put).
//   capacity_we_i/capacity_i write the capacity register; 0 acts as 1, values
//   above ENTRIES act as ENTRIES. write it only while the cache is idle.
//   the lookup word walks the row of ENTRIES cells, one cell per cycle, collecting
//   hit, first free slot and lru victim; then the update is applied to the cells
//   and the output register is loaded together. in_ready_o is high only while idle,
//   so a new word is taken only after the previous one has been applied.
//   a new word is accepted while the previous result still waits in the output
//   register; if the receiver stalls, the finished scan holds until the output
//   register frees.
//   reset clears all valid marks, ranks and the occupancy count, and sets
//   capacity to 16; key and value storage is not cleared.

module lru_key_value_cache_top #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               capacity_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0]         capacity_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lkvc_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [lkvc_pkg::KEY_W-1:0]  key_i,
  input  logic signed [lkvc_pkg::VAL_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               found_o,
  output logic signed [lkvc_pkg::VAL_W-1:0]  read_value_o
);
  import lkvc_pkg::*;

  localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int SCAN_W = 3 + 3 * IW + 2 * RW + VAL_W;
  localparam int CMD_W  = 4 + IW + RW + KEY_W + VAL_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  typedef struct packed {
    logic              hit;
    logic [IW-1:0]     hit_idx;
    logic [RW-1:0]     hit_rank;
    logic [VAL_W-1:0]  hit_value;
    logic              free;
    logic [IW-1:0]     free_idx;
    logic              any;
    logic [RW-1:0]     best;
    logic [IW-1:0]     victim;
  } scan_t;

  typedef struct packed {
    logic              upd;
    logic              age_all;
    logic              wr_key;
    logic              wr_val;
    logic [IW-1:0]     idx;
    logic [RW-1:0]     lim;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  logic [1:0]        state_q, state_d;
  logic              start_q;
  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FUNC_W-1:0] func_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic              out_valid_q;
  logic              found_q, found_d;
  logic [VAL_W-1:0]  rdata_q, rdata_d;

  logic [ENTRIES:0]  go;
  logic [SCAN_W-1:0] scan [ENTRIES+1];
  logic [ENTRIES-1:0] valid_vec;

  scan_t             res;
  cmd_t              cmd, cmd_gated;
  logic              done, fire, accept;
  logic [CMP_W-1:0]  cap_ext, eff_cap;

  assign go[0]   = start_q;
  assign scan[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkvc_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .go_i    (go[g]),
      .scan_i  (scan[g]),
      .cmd_i   (CMD_W'(cmd_gated)),
      .go_o    (go[g+1]),
      .scan_o  (scan[g+1]),
      .valid_o (valid_vec[g])
    );
  end

  assign res = scan_t'(scan[ENTRIES]);

  assign cap_ext = CMP_W'(cap_q);
  always_comb begin
    if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign done       = ((state_q == ST_SCAN) && go[ENTRIES]) || (state_q == ST_WAIT);
  assign fire       = done && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd         = '0;
    cmd.key     = key_q;
    cmd.value   = val_q;
    cnt_d       = cnt_q;
    found_d     = res.hit;
    rdata_d     = PUT_VALUE;
    if (func_q == FUNC_GET) begin
      if (res.hit) begin
        rdata_d = res.hit_value;
        cmd.upd = 1'b1;
        cmd.idx = res.hit_idx;
        cmd.lim = res.hit_rank;
      end else begin
        rdata_d = MISS_VALUE;
      end
    end else if (res.hit) begin
      cmd.upd    = 1'b1;
      cmd.wr_val = 1'b1;
      cmd.idx    = res.hit_idx;
      cmd.lim    = res.hit_rank;
    end else if (CMP_W'(cnt_q) < eff_cap) begin
      cmd.upd     = 1'b1;
      cmd.wr_key  = 1'b1;
      cmd.wr_val  = 1'b1;
      cmd.age_all = 1'b1;
      cmd.idx     = res.free_idx;
      cnt_d       = cnt_q + CNT_W'(1);
    end else begin
      cmd.upd    = 1'b1;
      cmd.wr_key = 1'b1;
      cmd.wr_val = 1'b1;
      cmd.idx    = res.victim;
      cmd.lim    = res.best;
      if (!res.any) begin
        cnt_d = CNT_W'(1);
      end
    end
  end

  always_comb begin
    cmd_gated     = cmd;
    cmd_gated.upd = cmd.upd && fire;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (go[ENTRIES]) begin
          state_d = fire ? ST_IDLE : ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      cap_q       <= CAP_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= accept;
      if (capacity_we_i) begin
        cap_q <= capacity_i;
      end
      if (fire) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      key_q  <= key_i;
      val_q  <= value_i;
    end
    if (fire) begin
      found_q <= found_d;
      rdata_q <= rdata_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign read_value_o = rdata_q;

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(cnt_q))
    else $error("occupancy count differs from valid marks");

  a_idle_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(|go) && !start_q)
    else $error("scan word in flight while idle");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN) && start_q)
    else $error("accepted word did not start a scan");

  a_no_update_outside_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_gated.upd |-> done && (!out_valid_q || out_ready_i))
    else $error("cell update issued outside the finish step");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for lru_key_value_cache_top with an lru scoreboard
// depends on lkvc_pkg and lru_key_value_cache_top

module testbench;
  import lkvc_pkg::*;

  localparam int N = ENTRIES_DEF;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] rd;
  } lookup_t;

  class lru_scoreboard;
    logic [KEY_W-1:0] slot_key [N];
    logic [VAL_W-1:0] slot_val [N];
    bit               slot_used [N];
    int unsigned      slot_age [N];
    int unsigned      used_cnt;
    logic [CAP_W-1:0] cap_reg;
    lookup_t          expected_q [$];
    int               errors, checked, gets, get_hits, puts, evictions;

    function new();
      cap_reg  = CAP_RESET;
      used_cnt = 0;
      foreach (slot_used[i]) begin
        slot_used[i] = 0;
        slot_age[i]  = 0;
      end
    endfunction

    task report(string what);
      $display("tb: mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      cap_reg = c;
    endfunction

    function int unsigned eff_cap();
      int unsigned c;
      c = cap_reg;
      if (c > N) c = N;
      if (c == 0) c = 1;
      return c;
    endfunction

    // entries newer than rank lim age by one, idx becomes newest
    function void promote(int idx, int unsigned lim);
      for (int i = 0; i < N; i++) begin
        if (slot_used[i] && i != idx && slot_age[i] < lim) slot_age[i]++;
      end
      slot_age[idx] = 0;
    endfunction

    function void install(int idx, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      slot_key[idx]  = k;
      slot_val[idx]  = v;
      slot_used[idx] = 1;
    endfunction

    function void note_request(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] k,
                               logic [VAL_W-1:0] v);
      lookup_t     exp;
      int          hit_at, free_at, victim;
      int unsigned oldest;
      hit_at = -1;
      for (int i = 0; i < N; i++) begin
        if (hit_at < 0 && slot_used[i] && slot_key[i] == k) hit_at = i;
      end
      exp.found = (hit_at >= 0);
      exp.rd    = PUT_VALUE;
      if (op == FUNC_GET) begin
        gets++;
        if (hit_at >= 0) begin
          get_hits++;
          exp.rd = slot_val[hit_at];
          promote(hit_at, slot_age[hit_at]);
        end else begin
          exp.rd = MISS_VALUE;
        end
      end else begin
        puts++;
        if (hit_at >= 0) begin
          slot_val[hit_at] = v;
          promote(hit_at, slot_age[hit_at]);
        end else if (used_cnt < eff_cap()) begin
          free_at = -1;
          for (int i = 0; i < N; i++) begin
            if (free_at < 0 && !slot_used[i]) free_at = i;
          end
          install(free_at, k, v);
          slot_age[free_at] = 0;
          promote(free_at, N + 1);
          used_cnt++;
        end else begin
          victim = -1;
          oldest = 0;
          for (int i = 0; i < N; i++) begin
            if (slot_used[i] && (victim < 0 || slot_age[i] > oldest)) begin
              victim = i;
              oldest = slot_age[i];
            end
          end
          evictions++;
          if (victim < 0) begin
            victim   = 0;
            used_cnt = 1;
          end
          install(victim, k, v);
          promote(victim, oldest);
        end
      end
      expected_q.insert(expected_q.size(), exp);
    endfunction

    task check_response(logic found, logic [VAL_W-1:0] rd);
      lookup_t exp;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected (found %b value %h)", found, rd));
      end else begin
        exp = expected_q.pop_front();
        if (found !== exp.found)
          report($sformatf("found %b, expected %b", found, exp.found));
        if (rd !== exp.rd)
          report($sformatf("read_value %h, expected %h", rd, exp.rd));
      end
    endtask
  endclass

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     capacity_we_i = 1'b0;
  logic [CAP_W-1:0]         capacity_i    = CAP_RESET;
  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic [FUNC_W-1:0]        func_i        = FUNC_GET;
  logic signed [KEY_W-1:0]  key_i         = '0;
  logic signed [VAL_W-1:0]  value_i       = '0;
  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic                     found_o;
  logic signed [VAL_W-1:0]  read_value_o;

  lru_scoreboard    sb = new();
  int               results_seen = 0;
  int unsigned      rcv_cyc = 0;
  int               hold_left = 0;
  bit               hold_done = 0;
  int               cap_settings = 1;
  logic [KEY_W-1:0] key_pool [24];

  lru_key_value_cache_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .capacity_we_i(capacity_we_i),
    .capacity_i   (capacity_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .read_value_o (read_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver: rotating stall patterns plus one long hold-off
  always @(negedge clk_i) begin
    rcv_cyc <= rcv_cyc + 1;
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_left   <= 200;
      hold_done   <= 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      case ((rcv_cyc / 64) % 4)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= (rcv_cyc % 4 == 0);
        default: out_ready_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_response(found_o, read_value_o);
      results_seen++;
    end
  end

  task send_word(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i     <= op;
    key_i      <= k;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, k, v);
  endtask

  task idle(int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task drain();
    idle(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (N + 4) @(posedge clk_i);
  endtask

  task write_capacity(logic [CAP_W-1:0] c);
    drain();
    @(negedge clk_i);
    capacity_we_i <= 1'b1;
    capacity_i    <= c;
    @(negedge clk_i);
    capacity_we_i <= 1'b0;
    sb.set_capacity(c);
    cap_settings++;
  endtask

  task run_random(int n, bit gappy, bit mid_pause);
    int               sent, burst, pool_n;
    bit               paused;
    logic [FUNC_W-1:0] op;
    logic [KEY_W-1:0]  k;
    sent   = 0;
    paused = 0;
    pool_n = sb.eff_cap() + 4;
    if (pool_n > 24) pool_n = 24;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && sent < n) begin
        op = $urandom_range(0, 1) ? FUNC_PUT : FUNC_GET;
        k  = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
        send_word(op, k, $urandom);
        sent++;
        burst--;
      end
      if (gappy) idle($urandom_range(1, 8));
      if (mid_pause && !paused && sent >= n / 2) begin
        drain();
        paused = 1;
      end
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [8];
    caps = '{5'd31, 5'd1, 5'd5, 5'd16, 5'd0, 5'd17, 5'd3, 5'd12};
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    for (int i = 4; i < 24; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty cache, extreme keys and values, update and hit/miss
    send_word(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    send_word(FUNC_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_word(FUNC_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_word(FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
    send_word(FUNC_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_word(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    send_word(FUNC_GET, 32'h7fff_ffff, 32'hffff_ffff);
    send_word(FUNC_GET, 32'hffff_ffff, 32'h0000_0000);
    send_word(FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
    send_word(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    send_word(FUNC_GET, 32'h0000_0001, 32'h0000_0000);
    // capacity below occupancy: old entries still hit, new keys evict
    write_capacity(5'd2);
    send_word(FUNC_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_word(FUNC_PUT, 32'h0000_0005, 32'h0000_0055);
    send_word(FUNC_GET, 32'h0000_0005, 32'h0000_0000);
    send_word(FUNC_PUT, 32'h0000_0006, 32'h0000_0066);
    send_word(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    // zero capacity acts as one
    write_capacity(5'd0);
    send_word(FUNC_PUT, 32'h0000_0007, 32'h0000_0077);
    send_word(FUNC_GET, 32'h0000_0007, 32'h0000_0000);
    send_word(FUNC_GET, 32'h0000_0006, 32'h0000_0000);

    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      run_random(50, (p != 2 && p != 5), (p == 4));
    end
    drain();

    $display("tb: %0d words checked over %0d capacity settings", sb.checked, cap_settings);
    $display("tb: %0d gets with %0d hits, %0d puts with %0d lru replacements",
             sb.gets, sb.get_hits, sb.puts, sb.evictions);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
